// ----- sv/ppo_pkg.sv -----
// ----------------------------------------------------------------------------
// ppo_pkg
// Shared widths, constants, register codes and pipeline payload types of the
// perspective projection and outcode unit.
// ----------------------------------------------------------------------------
package ppo_pkg;

  localparam int COORD_FRAC_BITS = 8;

  localparam int IN_W       = 24;
  localparam int DIM_W      = 13;
  localparam int FOC_W      = 16;
  localparam int OUT_W      = 32;
  localparam int CODE_W     = 4;
  localparam int PROD_W     = IN_W + FOC_W;
  localparam int NUM_W      = PROD_W + COORD_FRAC_BITS;
  localparam int REM_W      = IN_W;
  localparam int SUM_W      = NUM_W + 2;
  localparam int PIX_W      = OUT_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(320);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(256);
  localparam logic [FOC_W-1:0] FOCAL_RST  = FOC_W'(160);

  localparam logic signed [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [PIX_W-1:0] PIX_HALF = PIX_W'((64'd1 << COORD_FRAC_BITS) >> 1);

  localparam int OC_LEFT   = 0;
  localparam int OC_RIGHT  = 1;
  localparam int OC_TOP    = 2;
  localparam int OC_BOTTOM = 3;
  localparam logic [CODE_W-1:0] OC_ALL = {CODE_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_FOCAL  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic zero;
    logic last;
  } flags_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [NUM_W-1:0] nq;
  } lane_t;

  typedef struct packed {
    logic [REM_W-1:0] den;
    lane_t            lx;
    lane_t            ly;
    flags_t           flags;
  } div_t;

endpackage

// ----- sv/ppo_if.sv -----
// ----------------------------------------------------------------------------
// ppo_if
// Valid/ready channel interfaces: vertex input, projected result output and
// register write port.
// ----------------------------------------------------------------------------
interface ppo_vtx_if;
  import ppo_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] cam_x;
  logic signed [IN_W-1:0] cam_y;
  logic signed [IN_W-1:0] cam_z;
  logic                   last_vertex;

  modport source (output valid, cam_x, cam_y, cam_z, last_vertex, input ready);
  modport sink   (input valid, cam_x, cam_y, cam_z, last_vertex, output ready);
endinterface

interface ppo_res_if;
  import ppo_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] screen_x;
  logic signed [OUT_W-1:0] screen_y;
  logic [CODE_W-1:0]       outcode;
  logic                    zero_depth;
  logic                    last_out;

  modport source (output valid, screen_x, screen_y, outcode, zero_depth, last_out,
                  input ready);
  modport sink   (input valid, screen_x, screen_y, outcode, zero_depth, last_out,
                  output ready);
endinterface

interface ppo_cfg_if;
  import ppo_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/ppo_front.sv -----
// ----------------------------------------------------------------------------
// ppo_front
// Three-stage front end: take magnitudes and signs, multiply by the focal
// distance, then scale and add the rounding half of the divisor.
// ----------------------------------------------------------------------------
module ppo_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [ppo_pkg::IN_W-1:0] cam_x_i,
  input  logic signed [ppo_pkg::IN_W-1:0] cam_y_i,
  input  logic signed [ppo_pkg::IN_W-1:0] cam_z_i,
  input  logic                           last_i,
  input  logic [ppo_pkg::FOC_W-1:0]      focal_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ppo_pkg::div_t                  out_data_o
);
  import ppo_pkg::*;

  function automatic logic [IN_W-1:0] mag_in(input logic signed [IN_W-1:0] v);
    return v[IN_W-1] ? IN_W'(-v) : IN_W'(v);
  endfunction

  logic              a_valid_q, b_valid_q, c_valid_q;
  logic              a_ready, b_ready, c_ready;
  logic [IN_W-1:0]   ax_q, ay_q, az_q;
  flags_t            a_flags_q, b_flags_q;
  logic [PROD_W-1:0] bx_q, by_q, bx_d, by_d;
  logic [IN_W-1:0]   bz_q;
  div_t              c_data_q, c_data_d;

  assign c_ready    = !c_valid_q || out_ready_i;
  assign b_ready    = !b_valid_q || c_ready;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  assign bx_d = PROD_W'(ax_q) * PROD_W'(focal_i);
  assign by_d = PROD_W'(ay_q) * PROD_W'(focal_i);

  always_comb begin
    c_data_d          = '0;
    c_data_d.den      = bz_q;
    c_data_d.lx.nq    = (NUM_W'(bx_q) << COORD_FRAC_BITS) + NUM_W'(bz_q >> 1);
    c_data_d.ly.nq    = (NUM_W'(by_q) << COORD_FRAC_BITS) + NUM_W'(bz_q >> 1);
    c_data_d.flags    = b_flags_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
      if (c_ready) c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      ax_q            <= mag_in(cam_x_i);
      ay_q            <= mag_in(cam_y_i);
      az_q            <= mag_in(cam_z_i);
      a_flags_q.neg_x <= cam_x_i[IN_W-1] ~^ cam_z_i[IN_W-1];
      a_flags_q.neg_y <= cam_y_i[IN_W-1] ~^ cam_z_i[IN_W-1];
      a_flags_q.zero  <= (cam_z_i == '0);
      a_flags_q.last  <= last_i;
    end
    if (b_ready && a_valid_q) begin
      bx_q      <= bx_d;
      by_q      <= by_d;
      bz_q      <= az_q;
      b_flags_q <= a_flags_q;
    end
    if (c_ready && b_valid_q) begin
      c_data_q <= c_data_d;
    end
  end

  assign out_valid_o = c_valid_q;
  assign out_data_o  = c_data_q;

endmodule

// ----- sv/ppo_div_cell.sv -----
// ----------------------------------------------------------------------------
// ppo_div_cell
// One cell of the divider chain: develops one quotient bit for the x and the
// y lane by restoring compare and subtract, then hands the item on.
// ----------------------------------------------------------------------------
module ppo_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ppo_pkg::div_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ppo_pkg::div_t out_data_o
);
  import ppo_pkg::*;

  function automatic lane_t div_step(input lane_t l, input logic [REM_W-1:0] den);
    logic [REM_W:0] trial;
    logic           ge;
    lane_t          r;
    trial = {l.rem, l.nq[NUM_W-1]};
    ge    = (trial >= {1'b0, den});
    r.rem = ge ? REM_W'(trial - {1'b0, den}) : REM_W'(trial);
    r.nq  = {l.nq[NUM_W-2:0], ge};
    return r;
  endfunction

  logic valid_q;
  div_t data_q, data_d;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    data_d    = in_data_i;
    data_d.lx = div_step(in_data_i.lx, in_data_i.den);
    data_d.ly = div_step(in_data_i.ly, in_data_i.den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- sv/ppo_back.sv -----
// ----------------------------------------------------------------------------
// ppo_back
// Two-stage back end: apply sign, add centre and saturate, then round to
// pixels, form the outcode and hold the result in the output register.
// ----------------------------------------------------------------------------
module ppo_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ppo_pkg::div_t                   in_data_i,
  input  logic [ppo_pkg::DIM_W-1:0]       width_i,
  input  logic [ppo_pkg::DIM_W-1:0]       height_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [ppo_pkg::OUT_W-1:0] screen_x_o,
  output logic signed [ppo_pkg::OUT_W-1:0] screen_y_o,
  output logic [ppo_pkg::CODE_W-1:0]      outcode_o,
  output logic                            zero_depth_o,
  output logic                            last_out_o
);
  import ppo_pkg::*;

  function automatic logic signed [OUT_W-1:0] sat_sum(input logic [NUM_W-1:0] q,
                                                      input logic neg,
                                                      input logic [DIM_W-1:0] ext);
    logic signed [SUM_W-1:0] qs;
    logic signed [SUM_W-1:0] cen;
    logic signed [SUM_W-1:0] sum;
    qs  = $signed({2'b00, q});
    if (neg) qs = -qs;
    cen = $signed(SUM_W'(ext >> 1) << COORD_FRAC_BITS);
    sum = qs + cen;
    if (sum > SUM_W'(SAT_MAX)) sum = SUM_W'(SAT_MAX);
    if (sum < SUM_W'(SAT_MIN)) sum = SUM_W'(SAT_MIN);
    return OUT_W'(sum);
  endfunction

  function automatic logic [1:0] clip(input logic signed [OUT_W-1:0] s,
                                      input logic [DIM_W-1:0] ext);
    logic [OUT_W-1:0] mag;
    logic [PIX_W-1:0] pix;
    logic             below;
    mag   = s[OUT_W-1] ? OUT_W'(-s) : OUT_W'(s);
    pix   = (PIX_W'(mag) + PIX_HALF) >> COORD_FRAC_BITS;
    below = s[OUT_W-1] && (pix != '0);
    return {!below && (pix >= PIX_W'(ext)), below};
  endfunction

  logic                    s_valid_q, o_valid_q;
  logic                    s_ready, o_ready;
  logic signed [OUT_W-1:0] sx_q, sy_q, sx_d, sy_d;
  logic                    s_zero_q, s_last_q;
  logic signed [OUT_W-1:0] ox_q, oy_q;
  logic [CODE_W-1:0]       code_q, code_d;
  logic [1:0]              clip_x, clip_y;
  logic                    zero_q, last_q;

  assign o_ready    = !o_valid_q || out_ready_i;
  assign s_ready    = !s_valid_q || o_ready;
  assign in_ready_o = s_ready;

  always_comb begin
    sx_d = sat_sum(in_data_i.lx.nq, in_data_i.flags.neg_x, width_i);
    sy_d = sat_sum(in_data_i.ly.nq, in_data_i.flags.neg_y, height_i);
    if (in_data_i.flags.zero) begin
      sx_d = SAT_MAX;
      sy_d = SAT_MAX;
    end
  end

  always_comb begin
    clip_x            = clip(sx_q, width_i);
    clip_y            = clip(sy_q, height_i);
    code_d            = '0;
    code_d[OC_LEFT]   = clip_x[0];
    code_d[OC_RIGHT]  = clip_x[1];
    code_d[OC_TOP]    = clip_y[0];
    code_d[OC_BOTTOM] = clip_y[1];
    if (s_zero_q) code_d = OC_ALL;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (s_ready) s_valid_q <= in_valid_i;
      if (o_ready) o_valid_q <= s_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready && in_valid_i) begin
      sx_q     <= sx_d;
      sy_q     <= sy_d;
      s_zero_q <= in_data_i.flags.zero;
      s_last_q <= in_data_i.flags.last;
    end
    if (o_ready && s_valid_q) begin
      ox_q   <= sx_q;
      oy_q   <= sy_q;
      code_q <= code_d;
      zero_q <= s_zero_q;
      last_q <= s_last_q;
    end
  end

  assign out_valid_o  = o_valid_q;
  assign screen_x_o   = ox_q;
  assign screen_y_o   = oy_q;
  assign outcode_o    = code_q;
  assign zero_depth_o = zero_q;
  assign last_out_o   = last_q;

endmodule

// ----- sv/perspective_project_outcode_unit.sv -----
// ----------------------------------------------------------------------------
// perspective_project_outcode_unit
// Projects camera-space vertices to screen space with clip outcodes.
//
// Channels: vtx_i takes one vertex (cam_x, cam_y, cam_z in signed Q15.8 and
// last_vertex) per transaction; res_o gives one result per vertex, in order:
// screen_x, screen_y in signed Q23.8, saturated, the 4-bit outcode (left,
// right, top, bottom), zero_depth and last_out. cfg_i writes screen_width,
// screen_height and focal_distance by index 0, 1, 2; it is always ready and
// is to be written only while no vertex is in flight.
// Throughput: one vertex per cycle while res_o is not stalled. From vertex to
// result the data passes the three front stages, the 48-cell divider chain
// (one quotient bit per cell) and the two back stages.
// Every stage has its own valid and takes new data when empty or when its
// successor moves, so a stalled receiver fills the chain before vtx_i.ready
// falls, and bubbles close up.
// Reset empties all stages and loads 320, 256 and 160 into the registers.
// ----------------------------------------------------------------------------
module perspective_project_outcode_unit (
  input logic       clk_i,
  input logic       rst_ni,
  ppo_cfg_if.sink   cfg_i,
  ppo_vtx_if.sink   vtx_i,
  ppo_res_if.source res_o
);
  import ppo_pkg::*;

  logic [DIM_W-1:0] width_q, height_q;
  logic [FOC_W-1:0] focal_q;

  logic [NUM_W:0]   chain_valid;
  logic [NUM_W:0]   chain_ready;
  div_t             chain_data [NUM_W+1];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      focal_q  <= FOCAL_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_WIDTH:  width_q  <= cfg_i.data[DIM_W-1:0];
        REG_HEIGHT: height_q <= cfg_i.data[DIM_W-1:0];
        REG_FOCAL:  focal_q  <= cfg_i.data[FOC_W-1:0];
        default: ;
      endcase
    end
  end

  ppo_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vtx_i.valid),
    .in_ready_o  (vtx_i.ready),
    .cam_x_i     (vtx_i.cam_x),
    .cam_y_i     (vtx_i.cam_y),
    .cam_z_i     (vtx_i.cam_z),
    .last_i      (vtx_i.last_vertex),
    .focal_i     (focal_q),
    .out_valid_o (chain_valid[0]),
    .out_ready_i (chain_ready[0]),
    .out_data_o  (chain_data[0])
  );

  for (genvar k = 0; k < NUM_W; k++) begin : g_cell
    ppo_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[k]),
      .in_ready_o  (chain_ready[k]),
      .in_data_i   (chain_data[k]),
      .out_valid_o (chain_valid[k+1]),
      .out_ready_i (chain_ready[k+1]),
      .out_data_o  (chain_data[k+1])
    );
  end

  ppo_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (chain_valid[NUM_W]),
    .in_ready_o   (chain_ready[NUM_W]),
    .in_data_i    (chain_data[NUM_W]),
    .width_i      (width_q),
    .height_i     (height_q),
    .out_valid_o  (res_o.valid),
    .out_ready_i  (res_o.ready),
    .screen_x_o   (res_o.screen_x),
    .screen_y_o   (res_o.screen_y),
    .outcode_o    (res_o.outcode),
    .zero_depth_o (res_o.zero_depth),
    .last_out_o   (res_o.last_out)
  );

endmodule

// ----- sv/ppo_checker.sv -----
// ----------------------------------------------------------------------------
// ppo_checker
// Port-level checks of the projection unit: result hold under stall and
// consistency of the outcode with the projected coordinates.
// ----------------------------------------------------------------------------
module ppo_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            res_valid_i,
  input logic                            res_ready_i,
  input logic signed [ppo_pkg::OUT_W-1:0] res_screen_x_i,
  input logic signed [ppo_pkg::OUT_W-1:0] res_screen_y_i,
  input logic [ppo_pkg::CODE_W-1:0]      res_outcode_i,
  input logic                            res_zero_depth_i
);
  import ppo_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_screen_x_i)
      && $stable(res_screen_y_i) && $stable(res_outcode_i))
    else $error("result changed while stalled");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_zero_depth_i |-> res_outcode_i == OC_ALL
      && res_screen_x_i == SAT_MAX && res_screen_y_i == SAT_MAX)
    else $error("zero depth result not saturated");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_zero_depth_i |->
      !(res_outcode_i[OC_LEFT] && res_outcode_i[OC_RIGHT])
      && !(res_outcode_i[OC_TOP] && res_outcode_i[OC_BOTTOM]))
    else $error("opposite outcode bits both set");

  a_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_zero_depth_i && res_outcode_i[OC_LEFT] |-> res_screen_x_i[OUT_W-1])
    else $error("left bit set for non-negative x");

endmodule

bind perspective_project_outcode_unit ppo_checker u_ppo_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .res_screen_x_i   (res_o.screen_x),
  .res_screen_y_i   (res_o.screen_y),
  .res_outcode_i    (res_o.outcode),
  .res_zero_depth_i (res_o.zero_depth)
);

// ----- bench/perspective_project_outcode_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// perspective_project_outcode_unit_test
// Self-checking bench for the perspective projection unit. Drives vertices
// and register writes, with random idling on the vertex channel and random stalls of result ready. Predicts every
// projected point, with its outcode, from its own model of the block, and
// compares each result transaction field by field in order.
// ----------------------------------------------------------------------------
module perspective_project_outcode_unit_test;
  import ppo_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic signed [IN_W-1:0] IN_MAX = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic signed [IN_W-1:0] IN_MIN = {1'b1, {(IN_W-1){1'b0}}};
  localparam int LATENCY     = 53;
  localparam int PHASE_ITEMS = 175;
  localparam int CALM_ITEMS  = 150;
  localparam int NUM_PHASES  = 6;

  typedef struct {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] z;
    logic                   last;
  } vertex_t;

  typedef struct {
    logic signed [OUT_W-1:0] sx;
    logic signed [OUT_W-1:0] sy;
    logic [CODE_W-1:0]       code;
    logic                    zero_depth;
    logic                    last;
  } screen_pt_t;

  class projection_checker;
    longint unsigned width_px  = WIDTH_RST;
    longint unsigned height_px = HEIGHT_RST;
    longint unsigned focal     = FOCAL_RST;
    screen_pt_t      expected_points[$];
    int              failures  = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_WIDTH:  width_px  = value[DIM_W-1:0];
        REG_HEIGHT: height_px = value[DIM_W-1:0];
        REG_FOCAL:  focal     = value[FOC_W-1:0];
        default: ;
      endcase
    endfunction

    function longint project_axis(longint coord, longint depth, longint extent);
      longint unsigned mag_c;
      longint unsigned den;
      longint unsigned q;
      longint          sum;
      mag_c = (coord < 0) ? -coord : coord;
      den   = (depth < 0) ? -depth : depth;
      q     = (mag_c * focal * (64'd1 << COORD_FRAC_BITS) + den / 2) / den;
      sum   = ((coord < 0) == (depth < 0)) ? -longint'(q) : longint'(q);
      sum  += (extent >> 1) << COORD_FRAC_BITS;
      if (sum > longint'(SAT_MAX)) sum = longint'(SAT_MAX);
      if (sum < longint'(SAT_MIN)) sum = longint'(SAT_MIN);
      return sum;
    endfunction

    function longint round_pixel(longint v);
      longint unsigned m;
      m = (v < 0) ? -v : v;
      m = (m + ((64'd1 << COORD_FRAC_BITS) >> 1)) >> COORD_FRAC_BITS;
      return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function screen_pt_t project_vertex(vertex_t v);
      screen_pt_t p;
      longint     sx;
      longint     sy;
      longint     px;
      longint     py;
      p.last       = v.last;
      p.code       = '0;
      p.zero_depth = 1'b0;
      if (v.z == 0) begin
        p.sx         = SAT_MAX;
        p.sy         = SAT_MAX;
        p.code       = OC_ALL;
        p.zero_depth = 1'b1;
      end else begin
        sx   = project_axis(longint'(v.x), longint'(v.z), longint'(width_px));
        sy   = project_axis(longint'(v.y), longint'(v.z), longint'(height_px));
        p.sx = OUT_W'(sx);
        p.sy = OUT_W'(sy);
        px   = round_pixel(sx);
        py   = round_pixel(sy);
        if (px < 0) p.code[OC_LEFT] = 1'b1;
        else if (px > longint'(width_px) - 1) p.code[OC_RIGHT] = 1'b1;
        if (py < 0) p.code[OC_TOP] = 1'b1;
        else if (py > longint'(height_px) - 1) p.code[OC_BOTTOM] = 1'b1;
      end
      return p;
    endfunction

    function void note_vertex(vertex_t v);
      expected_points.push_back(project_vertex(v));
    endfunction

    function void check_result(screen_pt_t got);
      screen_pt_t exp_p;
      if (expected_points.size() == 0) begin
        $error("unexpected result: screen_x %0d screen_y %0d", got.sx, got.sy);
        failures++;
        return;
      end
      exp_p = expected_points.pop_front();
      if (got.sx !== exp_p.sx) begin
        $error("screen_x: expected %0d, actual %0d", exp_p.sx, got.sx);
        failures++;
      end
      if (got.sy !== exp_p.sy) begin
        $error("screen_y: expected %0d, actual %0d", exp_p.sy, got.sy);
        failures++;
      end
      if (got.code !== exp_p.code) begin
        $error("outcode: expected %0h, actual %0h", exp_p.code, got.code);
        failures++;
      end
      if (got.zero_depth !== exp_p.zero_depth) begin
        $error("zero_depth: expected %0b, actual %0b", exp_p.zero_depth, got.zero_depth);
        failures++;
      end
      if (got.last !== exp_p.last) begin
        $error("last_out: expected %0b, actual %0b", exp_p.last, got.last);
        failures++;
      end
    endfunction

    function int pending();
      return expected_points.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm = 1'b0;

  projection_checker chk = new();

  ppo_vtx_if vtx();
  ppo_res_if res();
  ppo_cfg_if cfg();

  perspective_project_outcode_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg),
    .vtx_i  (vtx),
    .res_o  (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    vertex_t    seen_v;
    screen_pt_t seen_p;
    if (rst_n) begin
      if (cfg.valid && cfg.ready) chk.write_reg(cfg.index, cfg.data);
      if (vtx.valid && vtx.ready) begin
        seen_v.x    = vtx.cam_x;
        seen_v.y    = vtx.cam_y;
        seen_v.z    = vtx.cam_z;
        seen_v.last = vtx.last_vertex;
        chk.note_vertex(seen_v);
      end
      if (res.valid && res.ready) begin
        seen_p.sx         = res.screen_x;
        seen_p.sy         = res.screen_y;
        seen_p.code       = res.outcode;
        seen_p.zero_depth = res.zero_depth;
        seen_p.last       = res.last_out;
        chk.check_result(seen_p);
      end
    end
  end

  initial begin
    res.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      res.ready <= 1'b1;
    end
  end

  function automatic vertex_t make_vertex(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y,
                                          logic signed [IN_W-1:0] z, logic last);
    vertex_t v;
    v.x    = x;
    v.y    = y;
    v.z    = z;
    v.last = last;
    return v;
  endfunction

  function automatic logic signed [IN_W-1:0] pick_coord();
    case ($urandom_range(0, 4))
      0: return IN_W'($urandom);
      1: return IN_W'(int'($urandom_range(0, 8191)) - 4096);
      2: return IN_W'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
      3: return IN_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      default: begin
        case ($urandom_range(0, 4))
          0: return IN_MAX;
          1: return IN_MIN;
          2: return 1;
          3: return -1;
          default: return 0;
        endcase
      end
    endcase
  endfunction

  task automatic send_vertex(input vertex_t v);
    if (!calm && $urandom_range(0, 5) == 0) begin
      vtx.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    vtx.valid       <= 1'b1;
    vtx.cam_x       <= v.x;
    vtx.cam_y       <= v.y;
    vtx.cam_z       <= v.z;
    vtx.last_vertex <= v.last;
    @(posedge clk);
    while (!vtx.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_random(input int count, input bit closing);
    vertex_t v;
    for (int i = 0; i < count; i++) begin
      if (closing && count - i <= CALM_ITEMS) calm = 1'b1;
      v.x    = pick_coord();
      v.y    = pick_coord();
      v.z    = ($urandom_range(0, 24) == 0) ? '0 : pick_coord();
      v.last = ($urandom_range(0, 7) == 0);
      send_vertex(v);
    end
  endtask

  task automatic wait_drained();
    while (chk.pending() != 0) @(negedge clk);
  endtask

  initial begin
    vtx.valid       <= 1'b0;
    vtx.cam_x       <= '0;
    vtx.cam_y       <= '0;
    vtx.cam_z       <= '0;
    vtx.last_vertex <= 1'b0;
    cfg.valid       <= 1'b0;
    cfg.index       <= REG_WIDTH;
    cfg.data        <= '0;
    rst_n           <= 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // z of -160.0 makes the scale one, so screen x is x plus the centre
    send_vertex(make_vertex(0, 0, 0, 1'b1));
    send_vertex(make_vertex(-41088, -32896, -40960, 1'b0));
    send_vertex(make_vertex(-41087, -32895, -40960, 1'b0));
    send_vertex(make_vertex(40832, 32640, -40960, 1'b0));
    send_vertex(make_vertex(40831, 32639, -40960, 1'b0));
    send_vertex(make_vertex(IN_MAX, IN_MIN, 1, 1'b0));
    send_vertex(make_vertex(IN_MIN, IN_MAX, -1, 1'b1));
    send_vertex(make_vertex(IN_MAX, IN_MAX, IN_MAX, 1'b0));
    send_vertex(make_vertex(IN_MIN, IN_MIN, IN_MIN, 1'b0));
    send_vertex(make_vertex(0, 0, IN_MIN, 1'b0));
    send_vertex(make_vertex(0, 0, IN_MAX, 1'b0));
    send_vertex(make_vertex(IN_MAX, IN_MIN, 0, 1'b0));
    send_vertex(make_vertex(256, -256, -256, 1'b0));
    send_vertex(make_vertex(1, -1, IN_MIN, 1'b1));
    send_vertex(make_vertex(-1, 1, 1, 1'b0));
    send_vertex(make_vertex(24'sh555555, 24'shAAAAAA, 24'sh5A5A5A, 1'b1));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        vtx.valid <= 1'b0;
        wait_drained();
        case (ph)
          1: begin
            write_reg(REG_WIDTH, 1);
            write_reg(REG_HEIGHT, 1);
            write_reg(REG_FOCAL, 1);
            write_reg(REG_SPARE, CFG_DATA_W'($urandom));
          end
          2: begin
            write_reg(REG_WIDTH, 4096);
            write_reg(REG_HEIGHT, 4096);
            write_reg(REG_FOCAL, 16'hFFFF);
          end
          3: begin
            write_reg(REG_WIDTH, 0);
            write_reg(REG_HEIGHT, 0);
            write_reg(REG_FOCAL, 0);
          end
          4: begin
            write_reg(REG_WIDTH, 16'hFFFF);
            write_reg(REG_HEIGHT, CFG_DATA_W'($urandom));
            write_reg(REG_FOCAL, CFG_DATA_W'($urandom));
          end
          default: begin
            write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(1, 4096)));
            write_reg(REG_HEIGHT, CFG_DATA_W'($urandom_range(1, 4096)));
            write_reg(REG_FOCAL, CFG_DATA_W'($urandom_range(1, 65535)));
          end
        endcase
      end
      send_random(PHASE_ITEMS, ph == NUM_PHASES - 1);
    end

    vtx.valid <= 1'b0;
    wait_drained();
    repeat (LATENCY + 8) @(negedge clk);
    if (chk.failures == 0 && chk.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(3_000_000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
